// ===== rtl/core/k_nearest_points_tracker_top_defines.svh =====
// assertion macros for the k nearest points tracker
// used by k_nearest_points_tracker_top; expects clock and reset in scope
`ifndef K_NEAREST_POINTS_TRACKER_TOP_DEFINES_SVH
`define K_NEAREST_POINTS_TRACKER_TOP_DEFINES_SVH

// same-cycle implication
`define KNPT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KNPT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/knpt_pkg.sv =====
// shared types, codes and distance helpers for the k nearest points tracker
// no dependencies
package knpt_pkg;

   localparam int COORD_W = 16;
   localparam int DIST_W  = 32;

   // command codes
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_LOAD   = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_REPORT
   } state_type;

   // x in the low half, y in the high half
   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } point_type;

   // control from the sequencer to the farthest-point tracker
   typedef struct packed {
      logic start;
      logic rd_valid;
   } scan_ctl_type;

   // exact squared distance, max 2^31 so it fits 32 bits unsigned
   function automatic logic [DIST_W-1:0] dist_f(input point_type p);
      logic signed [DIST_W-1:0] xx;
      logic signed [DIST_W-1:0] yy;
      xx = DIST_W'(p.x) * DIST_W'(p.x);
      yy = DIST_W'(p.y) * DIST_W'(p.y);
      return $unsigned(xx) + $unsigned(yy);
   endfunction

   // a strictly farther than b: distance, then x, then y
   function automatic logic farther_f(input logic [DIST_W-1:0] da, input point_type a,
                                      input logic [DIST_W-1:0] db, input point_type b);
      if (da != db) return da > db;
      if (a.x != b.x) return a.x > b.x;
      return a.y > b.y;
   endfunction

endpackage

// ===== rtl/core/knpt_if.sv =====
// item channel interfaces for the k nearest points tracker
// depends on knpt_pkg
interface knpt_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    command;
   logic signed [knpt_pkg::COORD_W-1:0] point_x;
   logic signed [knpt_pkg::COORD_W-1:0] point_y;

   modport source (output valid, command, point_x, point_y, input ready);
   modport sink   (input valid, command, point_x, point_y, output ready);
endinterface

interface knpt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic signed [knpt_pkg::COORD_W-1:0] far_x;
   logic signed [knpt_pkg::COORD_W-1:0] far_y;
   logic                          store_empty;

   modport source (output valid, far_x, far_y, store_empty, input ready);
   modport sink   (input valid, far_x, far_y, store_empty, output ready);
endinterface

// ===== rtl/core/knpt_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module knpt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rdata <= mem_ff[raddr];
   end
endmodule

// ===== rtl/core/knpt_best.sv =====
// tracks the farthest point seen during one pass over the store
// depends on knpt_pkg
module knpt_best #(
   parameter int ADDR_W = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  knpt_pkg::scan_ctl_type      ctl,
   input  knpt_pkg::point_type         rd_point,
   input  logic [ADDR_W-1:0]           rd_idx,
   output knpt_pkg::point_type         best_point,
   output logic [knpt_pkg::DIST_W-1:0] best_dist,
   output logic [ADDR_W-1:0]           best_idx
);
   import knpt_pkg::*;

   logic                has_ff;
   logic                has_in;
   logic                take;
   logic [DIST_W-1:0]   rd_dist;
   point_type           pt_ff;
   logic [DIST_W-1:0]   dist_ff;
   logic [ADDR_W-1:0]   idx_ff;

   // distance of the entry just read and compare against the best so far
   assign rd_dist = dist_f(rd_point);
   assign take    = ctl.rd_valid && (!has_ff || farther_f(rd_dist, rd_point, dist_ff, pt_ff));

   always_comb begin
      has_in = has_ff;
      if (ctl.start) begin
         has_in = 1'b0;
      end else if (take) begin
         has_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_ff <= 1'b0;
      end else begin
         has_ff <= has_in;
      end
   end

   // best payload
   always_ff @(posedge clock) begin
      if (!ctl.start && take) begin
         pt_ff   <= rd_point;
         dist_ff <= rd_dist;
         idx_ff  <= rd_idx;
      end
   end

   assign best_point = pt_ff;
   assign best_dist  = dist_ff;
   assign best_idx   = idx_ff;
endmodule

// ===== rtl/core/k_nearest_points_tracker_top.sv =====
// Clear, ignored command, load that fits or has nothing to evict: handled in idle.
// Evicting load: a scan, then the farthest entry is replaced by a nearer new point.
// Query: that update, a rescan, then a report that may wait on the result register.
// The store is one ram with one read port, scanned one entry per cycle to find the
// farthest point; this scan sets the item time. Reset empties the store (count 0,
// entries left unwritten) and sets k_count to 1; no clearing pass is needed.
module k_nearest_points_tracker_top #(
   parameter int MAX_K = 64
) (
   input  logic       clock,
   input  logic       reset,
   knpt_req_if.sink   req_if,
   knpt_rsp_if.source rsp_if,
   input  logic       csr_we,
   input  logic [6:0] csr_wdata
);
   import knpt_pkg::*;

   `include "k_nearest_points_tracker_top_defines.svh"

   localparam int ADDR_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int CNT_W  = $clog2(MAX_K + 1);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [6:0]         kreg_ff;
   logic [1:0]         cmd_ff;
   point_type          pt_ff;
   logic [DIST_W-1:0]  pdist_ff;
   logic               phase_ff, phase_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               rdv_ff, rdv_in;
   logic [ADDR_W-1:0]  rdidx_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   point_type          rsp_pt_ff;
   logic               rsp_empty_ff;

   logic               acc;
   logic               rsp_load;
   point_type          req_pt;
   logic [31:0]        eff_k;
   logic               evict_ld;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   point_type          mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;
   point_type          mem_rdata;
   scan_ctl_type       scan_ctl;
   point_type          best_pt;
   logic [DIST_W-1:0]  best_dist;
   logic [ADDR_W-1:0]  best_idx;
   logic               scan_done;
   logic               replace;

   // input decode
   assign acc      = req_if.valid && req_if.ready;
   assign req_pt   = '{y: req_if.point_y, x: req_if.point_x};
   assign eff_k    = (32'(kreg_ff) > 32'(MAX_K)) ? 32'(MAX_K) : 32'(kreg_ff);
   assign evict_ld = 32'(cnt_ff) >= eff_k;
   assign scan_done = (issue_ff == cnt_ff) && !rdv_ff;
   assign replace  = farther_f(best_dist, best_pt, pdist_ff, pt_ff);
   assign rsp_load = (state_ff == ST_REPORT) && (!rsp_valid_ff || rsp_if.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc && (req_if.command == CMD_QUERY ||
                        (req_if.command == CMD_LOAD && evict_ld))) begin
               if (cnt_ff != '0) begin
                  state_in = ST_SCAN;
                  phase_in = 1'b0;
               end else if (req_if.command == CMD_QUERY) begin
                  state_in = ST_REPORT;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = phase_ff ? ST_REPORT : ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (cmd_ff == CMD_QUERY) begin
               state_in = ST_SCAN;
               phase_in = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_REPORT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_if.ready      = (state_ff == ST_IDLE);
      mem_we            = 1'b0;
      mem_waddr         = cnt_ff[ADDR_W-1:0];
      mem_wdata         = req_pt;
      mem_raddr         = issue_ff[ADDR_W-1:0];
      scan_ctl.start    = 1'b0;
      scan_ctl.rd_valid = rdv_ff;
      cnt_in            = cnt_ff;
      issue_in          = issue_ff;
      rdv_in            = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (req_if.command == CMD_CLEAR) begin
                  cnt_in = '0;
               end else if (req_if.command == CMD_LOAD && !evict_ld) begin
                  mem_we = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            scan_ctl.start = 1'b1;
            issue_in       = '0;
         end
         ST_SCAN: begin
            if (issue_ff != cnt_ff) begin
               rdv_in   = 1'b1;
               issue_in = issue_ff + 1'b1;
            end
         end
         ST_DECIDE: begin
            mem_waddr      = best_idx;
            mem_wdata      = pt_ff;
            mem_we         = replace;
            scan_ctl.start = 1'b1;
            issue_in       = '0;
         end
         ST_REPORT: begin
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         kreg_ff      <= 7'd1;
         phase_ff     <= 1'b0;
         issue_ff     <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         issue_ff     <= issue_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            kreg_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (acc) begin
         cmd_ff   <= req_if.command;
         pt_ff    <= req_pt;
         pdist_ff <= dist_f(req_pt);
      end
      rdidx_ff <= issue_ff[ADDR_W-1:0];
      if (rsp_load) begin
         rsp_empty_ff <= (cnt_ff == '0);
         rsp_pt_ff    <= (cnt_ff == '0) ? point_type'('0) : best_pt;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.far_x       = rsp_pt_ff.x;
   assign rsp_if.far_y       = rsp_pt_ff.y;
   assign rsp_if.store_empty = rsp_empty_ff;

   // point store
   knpt_ram #(
      .WIDTH ($bits(point_type)),
      .DEPTH (MAX_K)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // farthest point tracker
   knpt_best #(
      .ADDR_W (ADDR_W)
   ) u_best (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .rd_point   (mem_rdata),
      .rd_idx     (rdidx_ff),
      .best_point (best_pt),
      .best_dist  (best_dist),
      .best_idx   (best_idx)
   );

   // checks
   `KNPT_ASSERT_NOW(a_cnt_bound, 1'b1, 32'(cnt_ff) <= 32'(MAX_K), "store count above depth")
   `KNPT_ASSERT_NEXT(a_clear, acc && req_if.command == CMD_CLEAR, cnt_ff == '0, "clear left points")
   `KNPT_ASSERT_NOW(a_we_state, mem_we, state_ff == ST_IDLE || state_ff == ST_DECIDE, "stray write")
   `KNPT_ASSERT_NOW(a_empty_zero, rsp_valid_ff && rsp_empty_ff,
                    rsp_pt_ff.x == 0 && rsp_pt_ff.y == 0, "empty result not zero")
endmodule

// ===== tb/k_nearest_points_tracker_top_test.sv =====
// testbench for the k nearest points tracker: directed and random points,
// with a scoreboard that models the kept store; depends on knpt_pkg and knpt_if
module k_nearest_points_tracker_top_test;
   import knpt_pkg::*;

   localparam int KMAX = 64;

   // one expected report
   typedef struct {
      logic signed [15:0] fx;
      logic signed [15:0] fy;
      logic               empty;
   } report_type;

   // kept-point store and expected reports
   class nearest_store;
      point_type  kept[KMAX];
      int         kept_n;
      int         k_reg;
      report_type pending[$];
      int         errors;

      function new();
         kept_n = 0;
         k_reg = 1;
         errors = 0;
      endfunction

      function bit is_farther(point_type a, point_type b);
         longint da;
         longint db;
         da = longint'(a.x) * a.x + longint'(a.y) * a.y;
         db = longint'(b.x) * b.x + longint'(b.y) * b.y;
         if (da != db) return da > db;
         if (a.x != b.x) return a.x > b.x;
         return a.y > b.y;
      endfunction

      function int far_index();
         int f;
         f = 0;
         for (int i = 1; i < kept_n && i < KMAX; i++)
            if (is_farther(kept[i], kept[f])) f = i;
         return f;
      endfunction

      function void place(point_type p, bit force_out);
         int k;
         int f;
         k = (k_reg > KMAX) ? KMAX : k_reg;
         if (!force_out && kept_n + 1 <= k) begin
            if (kept_n < KMAX) begin
               kept[kept_n] = p;
               kept_n++;
            end
            return;
         end
         if (kept_n == 0) return;
         f = far_index();
         if (is_farther(kept[f], p)) kept[f] = p;
      endfunction

      // note an accepted input item
      function void note_input(logic [1:0] cmd, point_type p);
         report_type r;
         if (cmd == CMD_CLEAR) kept_n = 0;
         else if (cmd == CMD_LOAD) place(p, 1'b0);
         else if (cmd == CMD_QUERY) begin
            place(p, 1'b1);
            if (kept_n == 0) begin
               r.fx = 0;
               r.fy = 0;
               r.empty = 1;
            end else begin
               r.fx = kept[far_index()].x;
               r.fy = kept[far_index()].y;
               r.empty = 0;
            end
            pending.push_back(r);
         end
      endfunction

      // check an accepted result item
      function void check_result(logic signed [15:0] fx, logic signed [15:0] fy, logic e);
         report_type r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected item, actual %0d %0d %b", $time, fx, fy, e);
            errors++;
            return;
         end
         r = pending.pop_front();
         if (e !== r.empty) begin
            $display("%0t: store_empty expected %b actual %b", $time, r.empty, e);
            errors++;
         end
         if (fx !== r.fx) begin
            $display("%0t: far_x expected %0d actual %0d", $time, r.fx, fx);
            errors++;
         end
         if (fy !== r.fy) begin
            $display("%0t: far_y expected %0d actual %0d", $time, r.fy, fy);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       csr_we = 0;
   logic [6:0] csr_wdata = 0;
   bit         sending_done = 0;
   bit         hold_off = 0;
   nearest_store board = new();

   knpt_req_if req_if ();
   knpt_rsp_if rsp_if ();

   k_nearest_points_tracker_top dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      req_if.valid = 0;
      req_if.command = CMD_CLEAR;
      req_if.point_x = 0;
      req_if.point_y = 0;
      rsp_if.ready = 0;
   end

   // input side bookkeeping
   always @(posedge clock)
      if (!reset && req_if.valid && req_if.ready)
         board.note_input(req_if.command, '{y: req_if.point_y, x: req_if.point_x});

   // result side checking
   always @(posedge clock)
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_result(rsp_if.far_x, rsp_if.far_y, rsp_if.store_empty);

   // receiver with random stalls and one long hold-off
   initial begin
      int w;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_if.ready <= 0;
            repeat (3000) @(posedge clock);
            hold_off = 0;
         end
         w = $urandom_range(0, 6);
         if ($urandom_range(0, 3) == 0) w = 0;
         if (w != 0) begin
            rsp_if.ready <= 0;
            repeat (w - 1) @(posedge clock);
            @(posedge clock);
         end
         rsp_if.ready <= 1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         rsp_if.ready <= 0;
      end
   end

   // offer one item and wait for its acceptance; valid stays high for a following item
   task automatic send_item(logic [1:0] cmd, logic [15:0] x, logic [15:0] y, bit gaps);
      int w;
      w = gaps ? $urandom_range(0, 6) : 0;
      if (w != 0) begin
         req_if.valid <= 0;
         repeat (w) @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.command <= cmd;
      req_if.point_x <= x;
      req_if.point_y <= y;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // write k_count once nothing is in flight
   task automatic write_k(int k);
      req_if.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (2 * KMAX + 20) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= 7'(k);
      @(posedge clock);
      csr_we <= 0;
      board.k_reg = k;
   endtask

   function automatic logic [15:0] rand_coord(int mode);
      case (mode)
         0: return 16'($urandom_range(0, 15)) - 16'd8;
         1: return 16'($urandom_range(0, 1023)) - 16'd512;
         default: return 16'($urandom);
      endcase
   endfunction

   // random phase at one k setting
   task automatic random_phase(int k, int n);
      int mode;
      int r;
      logic [1:0] cmd;
      write_k(k);
      mode = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         cmd = (r < 3) ? CMD_CLEAR : (r < 5) ? CMD_UNUSED : (r < 55) ? CMD_LOAD : CMD_QUERY;
         send_item(cmd, rand_coord(mode), rand_coord(mode), (i % 200) < 150);
      end
   endtask

   initial begin
      int ks[10];
      ks = '{1, 0, 64, 127, 3, 65, 8, 2, 17, 5};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty query, extremes, ties, clear, unused command
      send_item(CMD_QUERY, 16'h0000, 16'h0000, 0);
      send_item(CMD_LOAD, 16'h8000, 16'h8000, 0);
      send_item(CMD_QUERY, 16'h7fff, 16'h7fff, 0);
      send_item(CMD_QUERY, 16'h8000, 16'h8000, 0);
      send_item(CMD_CLEAR, 16'hffff, 16'hffff, 0);
      send_item(CMD_QUERY, 16'h8000, 16'h7fff, 0);
      send_item(CMD_UNUSED, 16'h1234, 16'hffff, 0);
      write_k(4);
      send_item(CMD_LOAD, 16'd3, 16'd4, 0);
      send_item(CMD_LOAD, 16'd4, 16'd3, 0);
      send_item(CMD_LOAD, -16'sd4, 16'd3, 0);
      send_item(CMD_LOAD, 16'd3, -16'sd4, 0);
      send_item(CMD_LOAD, 16'd5, 16'd0, 0);
      send_item(CMD_QUERY, 16'd0, 16'd5, 0);
      send_item(CMD_QUERY, 16'd1, 16'd1, 0);
      write_k(1);
      send_item(CMD_QUERY, 16'd0, 16'd0, 0);
      send_item(CMD_CLEAR, 16'd0, 16'd0, 0);
      write_k(0);
      send_item(CMD_LOAD, 16'd1, 16'd1, 0);
      send_item(CMD_QUERY, 16'd2, 16'd2, 0);
      // long receiver hold-off while the sender keeps offering
      write_k(8);
      hold_off = 1;
      for (int i = 0; i < 40; i++)
         send_item(CMD_QUERY, rand_coord(1), rand_coord(1), 0);
      foreach (ks[i]) random_phase(ks[i], 180);
      req_if.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (2 * KMAX + 20) @(posedge clock);
      if (board.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // overall time limit
   initial begin
      #30000000;
      $display("simulation failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/knpt_pkg.sv
rtl/core/knpt_if.sv
rtl/core/knpt_ram.sv
rtl/core/knpt_best.sv
rtl/core/k_nearest_points_tracker_top.sv
tb/k_nearest_points_tracker_top_test.sv
